### design/segi_pkg.sv
// shared widths, types and the divider step for the segment intersection unit
package segi_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int CRS_W  = PROD_W + 1;
    localparam int NUM_W  = CRS_W + DIFF_W + 1;
    localparam int QUO_W  = (COORD_BITS + 1 > FRAC_BITS) ? COORD_BITS + 1 : FRAC_BITS;
    localparam int REM_A  = (NUM_W > CRS_W + FRAC_BITS) ? NUM_W : CRS_W + FRAC_BITS;
    localparam int REM_W  = (REM_A > CRS_W + QUO_W) ? REM_A : CRS_W + QUO_W;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]     t_diff;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [CRS_W-1:0]      t_crs;
    typedef logic signed [NUM_W-1:0]      t_num;

    typedef struct packed {
        t_coord a_start_x;
        t_coord a_start_y;
        t_coord a_stop_x;
        t_coord a_stop_y;
        t_coord b_start_x;
        t_coord b_start_y;
        t_coord b_stop_x;
        t_coord b_stop_y;
    } t_item;

    // classified request handed from front to back
    typedef struct packed {
        logic             hit;
        logic [CRS_W-1:0] tn;
        logic [CRS_W-1:0] sn;
        logic [CRS_W-1:0] den;
        t_coord           ax0;
        t_coord           ay0;
        t_diff            dx;
        t_diff            dy;
    } t_qent;

    typedef struct packed {
        logic             hit;
        logic             nx;
        logic             ny;
        logic [CRS_W-1:0] den;
        logic [REM_W-1:0] rt;
        logic [REM_W-1:0] rs;
        logic [REM_W-1:0] rx;
        logic [REM_W-1:0] ry;
        logic [QUO_W-1:0] qt;
        logic [QUO_W-1:0] qs;
        logic [QUO_W-1:0] qx;
        logic [QUO_W-1:0] qy;
    } t_dstg;

    // one restoring step on all four dividends, quotient bits enter at the bottom
    function automatic t_dstg f_div_step(input t_dstg s, input int b);
        t_dstg            r;
        logic [REM_W-1:0] dsh;
        logic             gt, gs, gx, gy;
        r   = s;
        dsh = REM_W'(s.den) << b;
        gt  = (s.rt >= dsh);
        gs  = (s.rs >= dsh);
        gx  = (s.rx >= dsh);
        gy  = (s.ry >= dsh);
        if (gt) r.rt = s.rt - dsh;
        if (gs) r.rs = s.rs - dsh;
        if (gx) r.rx = s.rx - dsh;
        if (gy) r.ry = s.ry - dsh;
        r.qt = {s.qt[QUO_W-2:0], gt};
        r.qs = {s.qs[QUO_W-2:0], gs};
        r.qx = {s.qx[QUO_W-2:0], gx};
        r.qy = {s.qy[QUO_W-2:0], gy};
        return r;
    endfunction

endpackage

### design/segi_front.sv
// front pipeline: differences, cross products and crossing classification
module segi_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  segi_pkg::t_item   i_item,
    input  logic              i_q_full,
    output logic              o_full,
    output logic              o_push,
    output segi_pkg::t_qent   o_ent
);

    localparam int CW = segi_pkg::CRS_W;
    localparam int DW = segi_pkg::DIFF_W;

    logic en;
    logic r_v1, r_v2, r_v3, r_v4;

    segi_pkg::t_diff  r_dx, r_dy, r_ex, r_ey, r_px, r_py, r_fx, r_fy;
    segi_pkg::t_coord r_ax1, r_ay1, r_ax2, r_ay2, r_ax3, r_ay3;
    segi_pkg::t_diff  r_dx2, r_dy2, r_dx3, r_dy3;
    segi_pkg::t_prod  r_m [0:9];
    logic             r_deg2, r_deg3;
    segi_pkg::t_crs   r_c3, r_c4, r_den, r_tn, r_sn;
    segi_pkg::t_qent  r_ent;

    segi_pkg::t_crs   tn_n, sn_n, den_a;
    logic             side_ok, par_ok;

    assign en     = !(r_v4 && i_q_full);
    assign o_full = !en;
    assign o_push = r_v4 && !i_q_full;
    assign o_ent  = r_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // classification of the cross products, sign of den folded into the numerators
    always_comb begin
        den_a   = r_den[CW-1] ? -r_den : r_den;
        tn_n    = r_den[CW-1] ? -r_tn  : r_tn;
        sn_n    = r_den[CW-1] ? -r_sn  : r_sn;
        side_ok = (r_c3 != '0) && (r_c4 != '0) && (r_c3[CW-1] != r_c4[CW-1]);
        par_ok  = !tn_n[CW-1] && (tn_n != '0) && (tn_n < den_a)
               && !sn_n[CW-1] && (sn_n != '0) && (sn_n < den_a);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx  <= DW'(i_item.a_stop_x)  - DW'(i_item.a_start_x);
            r_dy  <= DW'(i_item.a_stop_y)  - DW'(i_item.a_start_y);
            r_ex  <= DW'(i_item.b_stop_x)  - DW'(i_item.b_start_x);
            r_ey  <= DW'(i_item.b_stop_y)  - DW'(i_item.b_start_y);
            r_px  <= DW'(i_item.b_start_x) - DW'(i_item.a_start_x);
            r_py  <= DW'(i_item.b_start_y) - DW'(i_item.a_start_y);
            r_fx  <= DW'(i_item.b_stop_x)  - DW'(i_item.a_start_x);
            r_fy  <= DW'(i_item.b_stop_y)  - DW'(i_item.a_start_y);
            r_ax1 <= i_item.a_start_x;
            r_ay1 <= i_item.a_start_y;

            r_m[0] <= r_dx * r_py;
            r_m[1] <= r_dy * r_px;
            r_m[2] <= r_dx * r_fy;
            r_m[3] <= r_dy * r_fx;
            r_m[4] <= r_dx * r_ey;
            r_m[5] <= r_dy * r_ex;
            r_m[6] <= r_px * r_ey;
            r_m[7] <= r_py * r_ex;
            r_m[8] <= r_px * r_dy;
            r_m[9] <= r_py * r_dx;
            r_deg2 <= ((r_dx == '0) && (r_dy == '0)) || ((r_ex == '0) && (r_ey == '0));
            r_ax2  <= r_ax1;
            r_ay2  <= r_ay1;
            r_dx2  <= r_dx;
            r_dy2  <= r_dy;

            r_c3   <= CW'(r_m[0]) - CW'(r_m[1]);
            r_c4   <= CW'(r_m[2]) - CW'(r_m[3]);
            r_den  <= CW'(r_m[4]) - CW'(r_m[5]);
            r_tn   <= CW'(r_m[6]) - CW'(r_m[7]);
            r_sn   <= CW'(r_m[8]) - CW'(r_m[9]);
            r_deg3 <= r_deg2;
            r_ax3  <= r_ax2;
            r_ay3  <= r_ay2;
            r_dx3  <= r_dx2;
            r_dy3  <= r_dy2;

            r_ent.hit <= !r_deg3 && side_ok && par_ok;
            r_ent.tn  <= tn_n;
            r_ent.sn  <= sn_n;
            r_ent.den <= den_a;
            r_ent.ax0 <= r_ax3;
            r_ent.ay0 <= r_ay3;
            r_ent.dx  <= r_dx3;
            r_ent.dy  <= r_dy3;
        end
    end

endmodule

### design/segi_fifo.sv
// short queue of classified requests between front and back
module segi_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  segi_pkg::t_qent i_data,
    output logic            o_full,
    input  logic            i_pop,
    output segi_pkg::t_qent o_data,
    output logic            o_empty
);

    localparam int PW = segi_pkg::QPTR_W;
    localparam int CNW = segi_pkg::QCNT_W;

    segi_pkg::t_qent  r_mem [0:segi_pkg::QDEPTH-1];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CNW-1:0]   r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNW'(segi_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + PW'(1);
            if (do_pop)  r_rp <= r_rp + PW'(1);
            if (do_push && !do_pop)      r_cnt <= r_cnt + CNW'(1);
            else if (do_pop && !do_push) r_cnt <= r_cnt - CNW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

endmodule

### design/segi_back.sv
// back pipeline: crossing point numerators and pipelined restoring dividers
module segi_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_empty,
    input  segi_pkg::t_qent                     i_ent,
    output logic                                o_q_pop,
    input  logic                                i_pop,
    output logic                                o_empty,
    output logic                                o_hit,
    output logic [segi_pkg::FRAC_BITS-1:0]      o_t_first,
    output logic [segi_pkg::FRAC_BITS-1:0]      o_t_second,
    output logic signed [segi_pkg::COORD_BITS-1:0] o_cross_x,
    output logic signed [segi_pkg::COORD_BITS-1:0] o_cross_y
);

    localparam int NW = segi_pkg::NUM_W;
    localparam int RW = segi_pkg::REM_W;
    localparam int QW = segi_pkg::QUO_W;
    localparam int CB = segi_pkg::COORD_BITS;
    localparam int FB = segi_pkg::FRAC_BITS;

    logic en;
    logic r_v0, r_ov;
    logic r_dv [0:QW];

    segi_pkg::t_num   r_mx, r_tx, r_my, r_ty;
    segi_pkg::t_qent  r_e0;
    segi_pkg::t_dstg  r_ds [0:QW];
    segi_pkg::t_dstg  fin;

    segi_pkg::t_num   sum_x, sum_y;
    logic [NW-1:0]    mag_x, mag_y;
    logic [QW-1:0]    qxs, qys;

    logic                  r_hit;
    logic [FB-1:0]         r_tf, r_ts;
    logic signed [CB-1:0]  r_cx, r_cy;

    assign en      = !r_ov || i_pop;
    assign o_q_pop = en && !i_q_empty;
    assign o_empty = !r_ov;
    assign o_hit      = r_hit;
    assign o_t_first  = r_tf;
    assign o_t_second = r_ts;
    assign o_cross_x  = r_cx;
    assign o_cross_y  = r_cy;

    always_comb begin
        sum_x = r_mx + r_tx;
        sum_y = r_my + r_ty;
        mag_x = sum_x[NW-1] ? NW'(-sum_x) : sum_x;
        mag_y = sum_y[NW-1] ? NW'(-sum_y) : sum_y;
        fin   = r_ds[QW];
        qxs   = fin.nx ? -fin.qx : fin.qx;
        qys   = fin.ny ? -fin.qy : fin.qy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_ov <= 1'b0;
            for (int k = 0; k <= QW; k++) r_dv[k] <= 1'b0;
        end else if (en) begin
            r_v0    <= o_q_pop;
            r_dv[0] <= r_v0;
            for (int k = 0; k < QW; k++) r_dv[k+1] <= r_dv[k];
            r_ov    <= r_dv[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // a_start*den + tn*d, later divided by den
            r_mx <= i_ent.ax0 * $signed({1'b0, i_ent.den});
            r_my <= i_ent.ay0 * $signed({1'b0, i_ent.den});
            r_tx <= $signed({1'b0, i_ent.tn}) * i_ent.dx;
            r_ty <= $signed({1'b0, i_ent.tn}) * i_ent.dy;
            r_e0 <= i_ent;

            r_ds[0].hit <= r_e0.hit;
            r_ds[0].nx  <= sum_x[NW-1];
            r_ds[0].ny  <= sum_y[NW-1];
            r_ds[0].den <= r_e0.den;
            r_ds[0].rt  <= RW'(r_e0.tn) << FB;
            r_ds[0].rs  <= RW'(r_e0.sn) << FB;
            r_ds[0].rx  <= RW'(mag_x);
            r_ds[0].ry  <= RW'(mag_y);
            r_ds[0].qt  <= '0;
            r_ds[0].qs  <= '0;
            r_ds[0].qx  <= '0;
            r_ds[0].qy  <= '0;

            for (int k = 0; k < QW; k++) begin
                r_ds[k+1] <= segi_pkg::f_div_step(r_ds[k], QW - 1 - k);
            end

            r_hit <= fin.hit;
            r_tf  <= fin.hit ? fin.qt[FB-1:0] : '0;
            r_ts  <= fin.hit ? fin.qs[FB-1:0] : '0;
            r_cx  <= fin.hit ? qxs[CB-1:0] : '0;
            r_cy  <= fin.hit ? qys[CB-1:0] : '0;
        end
    end

endmodule

### design/segment_intersection_unit.sv
// top level of the segment intersection unit
//  channel  | handshake          | payload
//  request  | i_push / o_full    | i_a_start_x .. i_b_stop_y
//  result   | o_empty / i_pop    | o_hit, o_t_first, o_t_second, o_cross_x, o_cross_y
// one request per cycle sustained while results are taken; a request passes the
// front, then the queue, then the back (two product/sum stages, 17 divider
// stages, output register) on its way to the result outputs
// synchronous active-low reset empties both pipelines and the queue
// a held result stalls the back; the front runs on until the 4-entry queue fills
module segment_intersection_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic signed [15:0] i_a_start_x,
    input  logic signed [15:0] i_a_start_y,
    input  logic signed [15:0] i_a_stop_x,
    input  logic signed [15:0] i_a_stop_y,
    input  logic signed [15:0] i_b_start_x,
    input  logic signed [15:0] i_b_start_y,
    input  logic signed [15:0] i_b_stop_x,
    input  logic signed [15:0] i_b_stop_y,
    output logic        o_empty,
    input  logic        i_pop,
    output logic        o_hit,
    output logic [15:0] o_t_first,
    output logic [15:0] o_t_second,
    output logic signed [15:0] o_cross_x,
    output logic signed [15:0] o_cross_y
);

    segi_pkg::t_item item;
    segi_pkg::t_qent f_ent, q_ent;
    logic            f_push, q_full, q_empty, q_pop;

    always_comb begin
        item.a_start_x = i_a_start_x;
        item.a_start_y = i_a_start_y;
        item.a_stop_x  = i_a_stop_x;
        item.a_stop_y  = i_a_stop_y;
        item.b_start_x = i_b_start_x;
        item.b_start_y = i_b_start_y;
        item.b_stop_x  = i_b_stop_x;
        item.b_stop_y  = i_b_stop_y;
    end

    segi_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .i_item   (item),
        .i_q_full (q_full),
        .o_full   (o_full),
        .o_push   (f_push),
        .o_ent    (f_ent)
    );

    segi_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_ent),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_ent),
        .o_empty (q_empty)
    );

    segi_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_ent      (q_ent),
        .o_q_pop    (q_pop),
        .i_pop      (i_pop),
        .o_empty    (o_empty),
        .o_hit      (o_hit),
        .o_t_first  (o_t_first),
        .o_t_second (o_t_second),
        .o_cross_x  (o_cross_x),
        .o_cross_y  (o_cross_y)
    );

endmodule

### design/segi_chk.sv
// port-level checker for the segment intersection unit and its bind
module segi_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_push,
    input logic        o_full,
    input logic        o_empty,
    input logic        i_pop,
    input logic        o_hit,
    input logic [15:0] o_t_first,
    input logic [15:0] o_t_second,
    input logic [15:0] o_cross_x,
    input logic [15:0] o_cross_y
);

    // a result that is not taken stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_hit) && $stable(o_t_first)
            && $stable(o_t_second) && $stable(o_cross_x) && $stable(o_cross_y)))
        else $error("held result changed");

    // a miss carries all-zero fields
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_hit) |-> (o_t_first == 16'd0 && o_t_second == 16'd0
            && o_cross_x == 16'd0 && o_cross_y == 16'd0))
        else $error("miss with nonzero fields");

    // right after reset nothing is waiting and requests are taken
    a_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> (o_empty && !o_full))
        else $error("not empty after reset");

    // the pipeline is deep: a result cannot appear in the cycle after reset
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(i_rst_n, 2) && $past(i_rst_n)) |-> o_empty)
        else $error("result too early after reset");

endmodule

bind segment_intersection_unit segi_chk u_chk (.*);

### bench/segment_intersection_checker.sv
// checker for the segment intersection unit: predicts each request's result and compares
`timescale 1ns / 1ps
module segment_intersection_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_full,
    input  logic signed [15:0] i_a_start_x,
    input  logic signed [15:0] i_a_start_y,
    input  logic signed [15:0] i_a_stop_x,
    input  logic signed [15:0] i_a_stop_y,
    input  logic signed [15:0] i_b_start_x,
    input  logic signed [15:0] i_b_start_y,
    input  logic signed [15:0] i_b_stop_x,
    input  logic signed [15:0] i_b_stop_y,
    input  logic               i_empty,
    input  logic               i_pop,
    input  logic               i_hit,
    input  logic [15:0]        i_t_first,
    input  logic [15:0]        i_t_second,
    input  logic signed [15:0] i_cross_x,
    input  logic signed [15:0] i_cross_y,
    output int                 o_errors,
    output int                 o_pending
);

    typedef struct {
        logic        hit;
        logic [15:0] tf;
        logic [15:0] ts;
        logic [15:0] cx;
        logic [15:0] cy;
    } t_crossing;

    t_crossing crossings_due[$];

    function automatic t_crossing crossing_of(input longint ax0, input longint ay0,
                                              input longint ax1, input longint ay1,
                                              input longint bx0, input longint by0,
                                              input longint bx1, input longint by1);
        t_crossing r;
        longint dx, dy, ex, ey, px, py, c3, c4, den, tn, sn;
        r = '{1'b0, 16'd0, 16'd0, 16'd0, 16'd0};
        dx = ax1 - ax0; dy = ay1 - ay0;
        ex = bx1 - bx0; ey = by1 - by0;
        px = bx0 - ax0; py = by0 - ay0;
        if ((dx == 0 && dy == 0) || (ex == 0 && ey == 0)) return r;
        c3 = dx * py - dy * px;
        c4 = dx * (by1 - ay0) - dy * (bx1 - ax0);
        if (c3 == 0 || c4 == 0 || ((c3 > 0) == (c4 > 0))) return r;
        den = dx * ey - dy * ex;
        tn = px * ey - py * ex;
        sn = px * dy - py * dx;
        if (den < 0) begin
            den = -den; tn = -tn; sn = -sn;
        end
        if (tn <= 0 || tn >= den || sn <= 0 || sn >= den) return r;
        r.hit = 1'b1;
        r.tf = 16'((tn <<< 16) / den);
        r.ts = 16'((sn <<< 16) / den);
        // longint division truncates toward zero
        r.cx = 16'((ax0 * den + tn * dx) / den);
        r.cy = 16'((ay0 * den + tn * dy) / den);
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            o_errors++;
        end
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_crossing want;
        if (i_rst_n && i_push && !i_full) begin
            crossings_due.push_back(crossing_of(i_a_start_x, i_a_start_y, i_a_stop_x,
                i_a_stop_y, i_b_start_x, i_b_start_y, i_b_stop_x, i_b_stop_y));
        end
        if (i_rst_n && i_pop && !i_empty) begin
            if (crossings_due.size() == 0) begin
                $error("result with no request waiting");
                o_errors++;
            end else begin
                want = crossings_due.pop_front();
                compare_field("hit", {15'd0, want.hit}, {15'd0, i_hit});
                compare_field("t_first", want.tf, i_t_first);
                compare_field("t_second", want.ts, i_t_second);
                compare_field("cross_x", want.cx, i_cross_x);
                compare_field("cross_y", want.cy, i_cross_y);
            end
        end
        o_pending = crossings_due.size();
    end

endmodule

### bench/segment_intersection_unit_tb.sv
// top of the segment intersection unit testbench: stimulus, clock, reset and verdict
`timescale 1ns / 1ps
module segment_intersection_unit_tb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_push = 1'b0;
    logic        i_pop = 1'b0;
    logic signed [15:0] c_ax0 = '0, c_ay0 = '0, c_ax1 = '0, c_ay1 = '0;
    logic signed [15:0] c_bx0 = '0, c_by0 = '0, c_bx1 = '0, c_by1 = '0;
    logic        o_full, o_empty, o_hit;
    logic [15:0] o_t_first, o_t_second;
    logic signed [15:0] o_cross_x, o_cross_y;
    int          errors, pending;
    int          cycles = 0;
    int          hold_off = 0;
    bit          stim_done = 0;

    always #6 i_clk = ~i_clk;

    segment_intersection_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .o_full(o_full),
        .i_a_start_x(c_ax0), .i_a_start_y(c_ay0), .i_a_stop_x(c_ax1), .i_a_stop_y(c_ay1),
        .i_b_start_x(c_bx0), .i_b_start_y(c_by0), .i_b_stop_x(c_bx1), .i_b_stop_y(c_by1),
        .o_empty(o_empty), .i_pop(i_pop), .o_hit(o_hit), .o_t_first(o_t_first),
        .o_t_second(o_t_second), .o_cross_x(o_cross_x), .o_cross_y(o_cross_y)
    );

    segment_intersection_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .i_full(o_full),
        .i_a_start_x(c_ax0), .i_a_start_y(c_ay0), .i_a_stop_x(c_ax1), .i_a_stop_y(c_ay1),
        .i_b_start_x(c_bx0), .i_b_start_y(c_by0), .i_b_stop_x(c_bx1), .i_b_stop_y(c_by1),
        .i_empty(o_empty), .i_pop(i_pop), .i_hit(o_hit), .i_t_first(o_t_first),
        .i_t_second(o_t_second), .i_cross_x(o_cross_x), .i_cross_y(o_cross_y),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("segment_intersection_unit_tb: errors");
            $finish;
        end
    end

    // offers one request and waits until it is taken; push stays high for a next
    // request that follows with no gap
    task automatic offer_pair(input int ax0, input int ay0, input int ax1, input int ay1,
                              input int bx0, input int by0, input int bx1, input int by1);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        c_ax0 <= 16'(ax0); c_ay0 <= 16'(ay0); c_ax1 <= 16'(ax1); c_ay1 <= 16'(ay1);
        c_bx0 <= 16'(bx0); c_by0 <= 16'(by0); c_bx1 <= 16'(bx1); c_by1 <= 16'(by1);
        i_push <= 1'b1;
        do @(posedge i_clk); while (o_full);
        @(negedge i_clk);
    endtask

    function automatic int rnd_coord(input int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    // random crossing pair: b endpoints spread around a point on segment a
    task automatic offer_crossing(input int span);
        int ax0, ay0, ax1, ay1, mx, my, vx, vy;
        ax0 = rnd_coord(span); ay0 = rnd_coord(span);
        ax1 = rnd_coord(span); ay1 = rnd_coord(span);
        mx = (ax0 + ax1) / 2; my = (ay0 + ay1) / 2;
        vx = rnd_coord(span / 2); vy = rnd_coord(span / 2);
        offer_pair(ax0, ay0, ax1, ay1, mx - vx, my - vy, mx + vx, my + vy);
    endtask

    // receiver: random stalls, plus one long hold-off driven by hold_off
    initial begin
        int wait_n;
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                i_pop <= 1'b0;
                hold_off = hold_off - 1;
            end else begin
                wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
                if (wait_n == 0) i_pop <= 1'b1;
                else begin
                    i_pop <= 1'b0;
                    repeat (wait_n) @(negedge i_clk);
                    i_pop <= 1'b1;
                end
            end
        end
    end

    initial begin
        int k, sel;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed: extremes, degenerate, endpoint on line, parallel, collinear, crossings
        offer_pair(0, 0, 0, 0, -5, 1, 5, -1);
        offer_pair(-10, 0, 10, 0, 3, 3, 3, 3);
        offer_pair(-10, 0, 10, 0, 0, 0, 0, 5);
        offer_pair(-10, 0, 10, 0, 0, -5, 0, 0);
        offer_pair(-10, 0, 10, 0, -10, 5, -10, -5);
        offer_pair(-10, 0, 10, 0, 10, 5, 10, -5);
        offer_pair(-10, 0, 10, 0, -5, 2, 5, 2);
        offer_pair(-10, 0, 10, 0, -20, 0, 20, 0);
        offer_pair(-10, 0, 10, 0, 20, 5, 20, -5);
        offer_pair(-10, 0, 10, 0, 3, 7, -4, -2);
        offer_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        offer_pair(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768);
        offer_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767);
        offer_pair(-32768, -32768, 32767, -32767, -32767, 32767, -32768, -32768);
        offer_pair(1, 1, 2, 3, 0, 3, 3, 1);
        offer_pair(-1, -1, -2, -3, 0, -3, -3, -1);
        offer_pair(0, 0, 3, 0, 1, 1, 2, -2);
        // receiver stalls long while requests keep coming, so the queue fills
        hold_off = 200;
        for (k = 0; k < 40; k++) offer_crossing(1000);
        i_push <= 1'b0;
        // sender pauses until everything has drained
        while (pending != 0) @(negedge i_clk);
        for (k = 0; k < 1800; k++) begin
            sel = $urandom_range(0, 9);
            if (sel < 5) offer_crossing(sel < 2 ? 32767 : 200);
            else if (sel < 8)
                offer_pair($urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom);
            else offer_pair(rnd_coord(4), rnd_coord(4), rnd_coord(4), rnd_coord(4),
                            rnd_coord(4), rnd_coord(4), rnd_coord(4), rnd_coord(4));
        end
        i_push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (errors == 0) $display("segment_intersection_unit_tb: clean");
        else $display("segment_intersection_unit_tb: errors");
        $finish;
    end

endmodule

### filelist.f
design/segi_pkg.sv
design/segi_front.sv
design/segi_fifo.sv
design/segi_back.sv
design/segment_intersection_unit.sv
design/segi_chk.sv
bench/segment_intersection_checker.sv
bench/segment_intersection_unit_tb.sv
